// File: hdl/b64enc_pkg.sv
package b64enc_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [6:0] CHAR_UPPER_A = 7'h41;
    localparam logic [6:0] CHAR_LOWER_A = 7'h61;
    localparam logic [6:0] CHAR_DIGIT_0 = 7'h30;
    localparam logic [6:0] CHAR_PLUS    = 7'h2B;
    localparam logic [6:0] CHAR_SLASH   = 7'h2F;
    localparam logic [6:0] CHAR_PAD     = 7'h3D;

    localparam logic [1:0] LAST_SLOT   = 2'd3;

    // One gathered group handed from front to back
    typedef struct packed {
        logic [23:0] bits;    // g0 in [23:16], zero-filled where absent
        logic [1:0]  nbytes;  // real bytes in the group, 1 to 3
        logic        last;    // group closes the message
    } group_t;

    function automatic logic [6:0] b64_char(input logic [5:0] s);
        logic [6:0] c;
        priority if (s < 6'd26)
            c = CHAR_UPPER_A + {1'b0, s};
        else if (s < 6'd52)
            c = CHAR_LOWER_A + {1'b0, s} - 7'd26;
        else if (s < 6'd62)
            c = CHAR_DIGIT_0 + {1'b0, s} - 7'd52;
        else if (s == 6'd62)
            c = CHAR_PLUS;
        else
            c = CHAR_SLASH;
        return c;
    endfunction

endpackage

// File: hdl/base64_stream_encoder.sv
// channel   handshake              payload
// in        in_valid / in_ready    data_byte[7:0], message_end
// out       out_valid / out_ready  out_char[6:0], run_last, stream_last
//
// Front takes one byte a cycle while the queue has room; a byte that only
// fills the group needs no room. Each finished group yields four characters
// in the back, one character a beat while out_ready is high. The closing
// group passes the queue and the back's group register to the output register.
// rst_n clears counts, queue pointers and valid flags; no sweep is needed.
// Either side may stall; the group queue lets the front run ahead.
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       message_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] out_char,
    output logic       run_last,
    output logic       stream_last
);
    import b64enc_pkg::*;

    logic   q_push;
    logic   q_pop;
    logic   q_not_full;
    logic   q_not_empty;
    group_t q_in;
    group_t q_out;

    b64enc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .message_end (message_end),
        .q_push      (q_push),
        .q_data      (q_in),
        .q_ready     (q_not_full)
    );

    b64enc_queue #(
        .QDepth (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .not_empty (q_not_empty)
    );

    b64enc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_not_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .run_last    (run_last),
        .stream_last (stream_last)
    );

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_not_full)
        else $error("group pushed into a full queue");

    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_not_empty)
        else $error("group popped from an empty queue");

    a_end_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && message_end) |=> q_not_empty)
        else $error("closing beat left no group queued");

    a_stream_last_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stream_last) |-> run_last)
        else $error("stream_last without run_last");

endmodule

// File: hdl/b64enc_front.sv
module b64enc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  logic                   message_end,
    output logic                   q_push,
    output b64enc_pkg::group_t     q_data,
    input  logic                   q_ready
);
    import b64enc_pkg::*;

    logic [7:0] pend_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] cnt_eff;
    logic       store;
    logic       accept;
    logic [7:0] g0, g1, g2;

    // a count of three never arises; treat it as two
    assign cnt_eff = (cnt_reg == 2'd3) ? 2'd2 : cnt_reg;
    assign store   = (cnt_eff < 2'd2) && !message_end;

    // a beat that is only stored needs no queue space
    assign in_ready = q_ready || store;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && !store;

    always_comb
    begin
        g0 = (cnt_eff == 2'd0) ? data_byte : pend_reg[0];
        g1 = (cnt_eff == 2'd1) ? data_byte : ((cnt_eff == 2'd2) ? pend_reg[1] : 8'd0);
        g2 = (cnt_eff == 2'd2) ? data_byte : 8'd0;
        q_data.bits   = {g0, g1, g2};
        q_data.nbytes = cnt_eff + 2'd1;
        q_data.last   = message_end;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
            cnt_next = store ? cnt_eff + 2'd1 : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && store)
            pend_reg[cnt_eff[0]] <= data_byte;
    end

endmodule

// File: hdl/b64enc_queue.sv
module b64enc_queue #(
    parameter int QDepth = b64enc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  b64enc_pkg::group_t     push_data,
    output logic                   not_full,
    input  logic                   pop,
    output b64enc_pkg::group_t     pop_data,
    output logic                   not_empty
);
    import b64enc_pkg::*;

    localparam int PtrW = $clog2(QDepth);
    localparam int CntW = $clog2(QDepth + 1);

    group_t          mem_reg [QDepth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;

    assign not_full  = (cnt_reg != CntW'(QDepth));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(QDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(QDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: hdl/b64enc_back.sv
module b64enc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  b64enc_pkg::group_t     q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [6:0]             out_char,
    output logic                   run_last,
    output logic                   stream_last
);
    import b64enc_pkg::*;

    group_t     cur_reg;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic       ov_reg, ov_next;
    logic [6:0] char_reg;
    logic       run_last_reg;
    logic       stream_last_reg;
    logic       load;
    logic       done;
    logic [5:0] slice;
    logic [6:0] ch;

    // output register frees when empty or being taken
    assign load  = busy_reg && (!ov_reg || out_ready);
    assign done  = load && (idx_reg == LAST_SLOT);
    assign q_pop = q_valid && (!busy_reg || done);

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    slice = cur_reg.bits[23:18];
            2'd1:    slice = cur_reg.bits[17:12];
            2'd2:    slice = cur_reg.bits[11:6];
            default: slice = cur_reg.bits[5:0];
        endcase
        // slot k carries a character while k <= bytes held
        ch = (idx_reg <= cur_reg.nbytes) ? b64_char(slice) : CHAR_PAD;
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        ov_next   = ov_reg;
        if (load)
        begin
            idx_next = idx_reg + 2'd1;
            ov_next  = 1'b1;
        end
        else if (out_ready)
            ov_next = 1'b0;
        if (done)
            busy_next = 1'b0;
        if (q_pop)
        begin
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_data;
        if (load)
        begin
            char_reg        <= ch;
            run_last_reg    <= (idx_reg == LAST_SLOT);
            stream_last_reg <= (idx_reg == LAST_SLOT) && cur_reg.last;
        end
    end

    assign out_valid   = ov_reg;
    assign out_char    = char_reg;
    assign run_last    = run_last_reg;
    assign stream_last = stream_last_reg;

endmodule

// File: tb/sv/base64_stream_encoder_tb.sv
`timescale 1ns / 1ps

module base64_stream_encoder_tb;
    import b64enc_pkg::*;

    localparam int CYCLE_LIMIT = 250000;
    localparam int DRAIN_CYCLES = 12;
    localparam bit [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [6:0] ch;
        logic       run_last;
        logic       stream_last;
    } enc_char_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       message_end;
    logic       out_valid;
    logic       out_ready;
    logic [6:0] out_char;
    logic       run_last;
    logic       stream_last;

    enc_char_t  expected_chars[$];
    enc_char_t  want;
    logic [7:0] held_bytes[2];
    int         held_cnt = 0;

    int err_cnt    = 0;
    int cycle_cnt  = 0;
    int bytes_sent = 0;
    int msgs_sent  = 0;
    int chars_seen = 0;
    bit idle_on    = 1'b0;
    int rx_hold    = 0;
    int rx_stall   = 0;

    base64_stream_encoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .message_end (message_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .run_last    (run_last),
        .stream_last (stream_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        data_byte   <= 8'h00;
        message_end <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d characters still awaited", $time,
                     expected_chars.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [6:0] sextet_char(input logic [5:0] s);
        return ALPHABET[8*(63 - s) +: 7];
    endfunction

    // Gathers bytes into groups of three; a completed group or a message end
    // yields four characters, padded where the group is short.
    task automatic predict_encoding(input logic [7:0] b, input logic e);
        logic [23:0] grp;
        int          nchars;
        enc_char_t   c;
        if (held_cnt < 2 && !e)
        begin
            held_bytes[held_cnt] = b;
            held_cnt++;
        end
        else
        begin
            case (held_cnt)
                0:       grp = {b, 16'h0000};
                1:       grp = {held_bytes[0], b, 8'h00};
                default: grp = {held_bytes[0], held_bytes[1], b};
            endcase
            nchars = held_cnt + 2;
            for (int k = 0; k < 4; k++)
            begin
                c.ch          = (k < nchars) ? sextet_char(grp[23 - 6*k -: 6]) : CHAR_PAD;
                c.run_last    = (k == 3);
                c.stream_last = (k == 3) && e;
                expected_chars.push_back(c);
            end
            held_cnt = 0;
        end
    endtask

    // Called at a rising edge; returns at the edge the beat is taken.
    task automatic send_byte(input logic [7:0] b, input logic e);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        message_end <= e;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_encoding(b, e);
        bytes_sent++;
        if (e)
            msgs_sent++;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    function automatic int pick_length();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 9);
    endfunction

    task automatic drain_output();
        in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Receiver: long hold first, then short random stall bursts
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold--;
        end
        else if (rx_stall > 0)
        begin
            out_ready <= 1'b0;
            rx_stall--;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            out_ready <= 1'b0;
            rx_stall = $urandom_range(1, 11) - 1;
        end
        else
            out_ready <= 1'b1;
    end

    initial out_ready <= 1'b0;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            chars_seen++;
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected character: expected none, got %h", $time,
                         out_char);
                err_cnt++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (out_char !== want.ch)
                begin
                    $display("%0t: out_char mismatch: expected %h, got %h", $time,
                             want.ch, out_char);
                    err_cnt++;
                end
                if (run_last !== want.run_last)
                begin
                    $display("%0t: run_last mismatch: expected %b, got %b", $time,
                             want.run_last, run_last);
                    err_cnt++;
                end
                if (stream_last !== want.stream_last)
                begin
                    $display("%0t: stream_last mismatch: expected %b, got %b", $time,
                             want.stream_last, stream_last);
                    err_cnt++;
                end
            end
        end
    end

    // One, two and three byte messages, and a group followed by a short tail
    task automatic test_known_vectors();
        idle_on = 1'b0;
        send_byte("M", 1'b1);
        send_byte("M", 1'b0);
        send_byte("a", 1'b1);
        send_byte("M", 1'b0);
        send_byte("a", 1'b0);
        send_byte("n", 1'b1);
        send_byte("M", 1'b0);
        send_byte("a", 1'b0);
        send_byte("n", 1'b0);
        send_byte("y", 1'b1);
        drain_output();
    endtask

    // All-zero, all-one, '+' and '/' groups, and extreme bytes left alone at the end
    task automatic test_edge_bytes();
        idle_on = 1'b1;
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        drain_output();
    endtask

    task automatic test_random_messages(input int target);
        int stop_at;
        stop_at = bytes_sent + target;
        idle_on = 1'b1;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
                idle_on = !idle_on;
            send_message(pick_length());
        end
        drain_output();
    endtask

    // Receiver holds off while bytes keep coming, so the input must stall
    task automatic test_output_hold();
        idle_on = 1'b0;
        rx_hold = 160;
        send_message(7);
        send_message(1);
        send_message(12);
        send_message(2);
        send_message(14);
        drain_output();
    endtask

    task automatic test_back_to_back(input int target);
        int stop_at;
        stop_at = bytes_sent + target;
        idle_on = 1'b0;
        while (bytes_sent < stop_at)
            send_message(pick_length());
        drain_output();
    endtask

    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        test_known_vectors();
        test_edge_bytes();
        test_random_messages(270);
        test_output_hold();
        test_back_to_back(115);
        $display("Encoded %0d bytes in %0d messages, %0d characters checked,", bytes_sent,
                 msgs_sent, chars_seen);
        $display("with random stalls on both sides and one long output hold.");
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
